// ===== rtl/edc_pkg.sv =====
package edc_pkg;

  // Default sizes of the car and of the passenger counters.
  localparam int FLOORS_DEF     = 8;
  localparam int COUNT_BITS_DEF = 8;

  // Door dwell after reset, in ticks.
  localparam logic [3:0] DWELL_RESET = 4'd5;

  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // Flags that ripple from floor 0 upward through the cell chain.
  typedef struct packed {
    logic any_up;     // request strictly above the car
    logic any_down;   // request strictly below the car
    logic stop_up;    // car would stop one floor up while heading up
    logic stop_down;  // car would stop one floor down while heading down
    logic stop_here;  // request at the car's own floor
  } wave_t;

  // Commands from the sequencer to the floor selected on the shared bus.
  typedef struct packed {
    logic set_call;   // register a hall call
    logic call_dir;   // hall direction of that call, 1 = down
    logic clear;      // door opens here: drop riders and hall call
    logic add;        // boarding: add riders bound for this floor
  } cell_ctrl_t;

endpackage

// ===== rtl/edc_in_if.sv =====
interface edc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [2:0] call_floor;
  logic       call_dir;
  logic [2:0] dest_floor;

  modport source (output valid, func, call_floor, call_dir, dest_floor, input ready);
  modport sink   (input valid, func, call_floor, call_dir, dest_floor, output ready);
endinterface

// ===== rtl/edc_out_if.sv =====
interface edc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] car_floor;
  logic [1:0] car_dir;
  logic       door_opened;
  logic [3:0] dwell_left;
  logic       status;

  modport source (output valid, car_floor, car_dir, door_opened, dwell_left, status,
                  input ready);
  modport sink   (input valid, car_floor, car_dir, door_opened, dwell_left, status,
                  output ready);
endinterface

// ===== rtl/edc_floor_cell.sv =====
module edc_floor_cell
  import edc_pkg::*;
#(
  parameter int FLOOR_W    = 3,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FLOOR_ID   = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [FLOOR_W-1:0]    sel_floor_i,
  input  logic [COUNT_BITS-1:0] add_count_i,
  input  logic [FLOOR_W-1:0]    car_level_i,
  input  wave_t                 wave_i,
  output wave_t                 wave_o
);

  localparam logic [FLOOR_W-1:0] MyFloor   = FLOOR_W'(FLOOR_ID);
  localparam logic [FLOOR_W:0]   MyFloorX  = (FLOOR_W+1)'(FLOOR_ID);

  logic [COUNT_BITS-1:0] riders_q;
  logic                  pend_q;
  logic                  hdir_q;
  wave_t                 wave_q;

  logic                  is_sel;
  logic                  at_car;
  logic                  has_req;
  logic [FLOOR_W:0]      car_x;
  logic [COUNT_BITS:0]   sum;

  assign is_sel  = (sel_floor_i == MyFloor);
  assign at_car  = (car_level_i == MyFloor);
  assign has_req = pend_q || (riders_q != '0);
  assign car_x   = {1'b0, car_level_i};
  assign sum     = {1'b0, riders_q} + {1'b0, add_count_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      riders_q <= '0;
      pend_q   <= 1'b0;
      hdir_q   <= 1'b0;
    end else if (is_sel) begin
      if (ctrl_i.clear) begin
        riders_q <= '0;
        pend_q   <= 1'b0;
        hdir_q   <= 1'b0;
      end else if (ctrl_i.set_call) begin
        pend_q <= 1'b1;
        hdir_q <= ctrl_i.call_dir;
      end else if (ctrl_i.add && !at_car) begin
        riders_q <= sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
      end
    end
  end

  // Each cell folds its own floor into the flags and hands them on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q.any_up    <= wave_i.any_up || (has_req && (MyFloor > car_level_i));
      wave_q.any_down  <= wave_i.any_down || (has_req && (MyFloor < car_level_i));
      wave_q.stop_up   <= wave_i.stop_up || ((car_x + 1'b1 == MyFloorX) &&
                          ((riders_q != '0) || (pend_q && !hdir_q)));
      wave_q.stop_down <= wave_i.stop_down || ((car_x == MyFloorX + 1'b1) &&
                          ((riders_q != '0) || (pend_q && hdir_q)));
      wave_q.stop_here <= wave_i.stop_here || (at_car && has_req);
    end
  end

  assign wave_o = wave_q;

endmodule

// ===== rtl/elevator_direction_controller_unit.sv =====
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    func, call_floor, call_dir, dest_floor
// out_o     out  valid/ready    car_floor, car_dir, door_opened, dwell_left, status
// apb       in   psel/penable   dwell_ticks at byte address 0
//
// A call passes through S_CALL to S_DONE, or goes straight to S_DONE when a floor lies
// beyond the top floor; a tick while the door is open goes straight to S_DONE.
// A tick with the door closed waits in S_SCAN for the request flags to ripple
// through the floor chain, decides in S_DECIDE, and an opening tick then walks in
// S_WALK over the waiting counts of that floor.
// After reset the waiting-count memory is swept clear, one entry a cycle, over all
// FLOORS * 2**clog2(FLOORS) entries; no item is accepted until the sweep ends.
// A result waits in the output register; the sequencer stalls only when it has a
// new result and the previous one has not been taken.
module elevator_direction_controller_unit
  import edc_pkg::*;
#(
  parameter int FLOORS     = FLOORS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  edc_in_if.sink      in_i,
  edc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Floor index width, widened copy for the 3-bit ports, memory address width.
  localparam int FW        = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int XW        = (FW > 3) ? FW : 3;
  localparam int AW        = 2 * FW;
  localparam int MEM_DEPTH = FLOORS << FW;

  localparam logic [AW-1:0] ClrLast    = AW'(MEM_DEPTH - 1);
  localparam logic [FW:0]   CntFloors  = (FW+1)'(FLOORS);
  localparam logic [FW:0]   CntLast    = (FW+1)'(FLOORS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALL   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_WALK   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]      state_q;
  logic [FW:0]     cnt_q;
  logic [AW-1:0]   clr_q;
  logic [FW-1:0]   car_level_q;
  dir_e            car_dir_q;
  logic [3:0]      dwell_q;
  logic [3:0]      dwell_ticks_q;
  logic [FW-1:0]   call_floor_q;
  logic [FW-1:0]   dest_floor_q;
  logic            call_dir_q;
  logic            status_q;
  logic            opened_q;

  logic            out_valid_q;
  logic [2:0]      out_floor_q;
  logic [1:0]      out_dir_q;
  logic            out_opened_q;
  logic [3:0]      out_dwell_q;
  logic            out_status_q;

  // Waiting passengers, addressed by {boarding floor, destination floor}.
  logic [COUNT_BITS-1:0] wait_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0] mem_rd_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [AW-1:0]         mem_ra;
  logic [COUNT_BITS-1:0] mem_wd;

  logic [XW-1:0]   in_cf_x;
  logic [XW-1:0]   in_df_x;
  logic [FW-1:0]   in_cf;
  logic [FW-1:0]   in_df;
  logic            in_range;
  logic            accept;
  logic            out_load;
  logic            wait_full;

  wave_t           wave [FLOORS+1];
  wave_t           scan;
  cell_ctrl_t      ctrl;
  logic [FW-1:0]   sel_floor;
  logic [FW:0]     cnt_m1;

  dir_e            dir_nx;
  logic [FW-1:0]   level_nx;
  logic            open_nx;

  // ---------------------------------------------------------------------------
  // Configuration port. pready is tied high; addresses 4 to 7 read as zero.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {28'd0, dwell_ticks_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= DWELL_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      dwell_ticks_q <= pwdata[3:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode. Floors beyond the top floor make a call void.
  // ---------------------------------------------------------------------------
  assign in_cf_x  = XW'(in_i.call_floor);
  assign in_df_x  = XW'(in_i.dest_floor);
  assign in_cf    = in_cf_x[FW-1:0];
  assign in_df    = in_df_x[FW-1:0];
  assign in_range = (32'(in_i.call_floor) < FLOORS) && (32'(in_i.dest_floor) < FLOORS);

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign wait_full  = &mem_rd_q;
  assign cnt_m1     = cnt_q - (FW+1)'(1);

  // ---------------------------------------------------------------------------
  // Chain of floor cells. The request flags enter at floor 0 and pass through a
  // register in every cell on their way to the end of the chain.
  // ---------------------------------------------------------------------------
  assign wave[0] = '0;

  for (genvar g = 0; g < FLOORS; g++) begin : g_floor
    edc_floor_cell #(
      .FLOOR_W    (FW),
      .COUNT_BITS (COUNT_BITS),
      .FLOOR_ID   (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sel_floor_i (sel_floor),
      .add_count_i (mem_rd_q),
      .car_level_i (car_level_q),
      .wave_i      (wave[g]),
      .wave_o      (wave[g+1])
    );
  end

  assign scan = wave[FLOORS];

  // ---------------------------------------------------------------------------
  // Direction choice: keep heading while requests lie ahead, else reverse,
  // else go idle. The stop flags were computed for all three possible next floors.
  // ---------------------------------------------------------------------------
  always_comb begin
    case (car_dir_q)
      DIR_UP:   dir_nx = scan.any_up ? DIR_UP :
                         (scan.any_down ? DIR_DOWN : DIR_IDLE);
      DIR_DOWN: dir_nx = scan.any_down ? DIR_DOWN :
                         (scan.any_up ? DIR_UP : DIR_IDLE);
      default:  dir_nx = scan.any_up ? DIR_UP :
                         (scan.any_down ? DIR_DOWN : DIR_IDLE);
    endcase
    case (dir_nx)
      DIR_UP: begin
        level_nx = car_level_q + 1'b1;
        open_nx  = scan.stop_up;
      end
      DIR_DOWN: begin
        level_nx = car_level_q - 1'b1;
        open_nx  = scan.stop_down;
      end
      default: begin
        level_nx = car_level_q;
        open_nx  = scan.stop_here;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Cell commands and memory access per state.
  // ---------------------------------------------------------------------------
  always_comb begin
    ctrl      = '0;
    sel_floor = call_floor_q;
    mem_we    = 1'b0;
    mem_wa    = clr_q;
    mem_wd    = '0;
    mem_ra    = {in_cf, in_df};
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_CALL: begin
        if (!wait_full) begin
          ctrl.set_call = 1'b1;
          ctrl.call_dir = call_dir_q;
          mem_we        = 1'b1;
          mem_wa        = {call_floor_q, dest_floor_q};
          mem_wd        = mem_rd_q + COUNT_BITS'(1);
        end
      end
      S_DECIDE: begin
        sel_floor  = level_nx;
        ctrl.clear = open_nx;
      end
      S_WALK: begin
        // Read and clear one destination count per cycle; the count read in
        // the previous cycle is added to its destination floor.
        sel_floor = cnt_m1[FW-1:0];
        ctrl.add  = (cnt_q != '0);
        mem_ra    = {car_level_q, cnt_q[FW-1:0]};
        if (cnt_q != CntFloors) begin
          mem_we = 1'b1;
          mem_wa = {car_level_q, cnt_q[FW-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wait_mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= wait_mem[mem_ra];
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      clr_q        <= '0;
      car_level_q  <= '0;
      car_dir_q    <= DIR_IDLE;
      dwell_q      <= '0;
      call_floor_q <= '0;
      dest_floor_q <= '0;
      call_dir_q   <= 1'b0;
      status_q     <= 1'b0;
      opened_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ClrLast) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            call_floor_q <= in_cf;
            dest_floor_q <= in_df;
            call_dir_q   <= in_i.call_dir;
            status_q     <= 1'b0;
            opened_q     <= 1'b0;
            cnt_q        <= '0;
            if (in_i.func) begin
              state_q <= in_range ? S_CALL : S_DONE;
            end else if (dwell_q != 4'd0) begin
              dwell_q <= dwell_q - 4'd1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_CALL: begin
          status_q <= wait_full;
          state_q  <= S_DONE;
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntLast) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          car_dir_q   <= dir_nx;
          car_level_q <= level_nx;
          cnt_q       <= '0;
          if (open_nx) begin
            opened_q <= 1'b1;
            dwell_q  <= dwell_ticks_q;
            state_q  <= S_WALK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_WALK: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntFloors) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_floor_q  <= 3'(car_level_q);
      out_dir_q    <= car_dir_q;
      out_opened_q <= opened_q;
      out_dwell_q  <= dwell_q;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.car_floor   = out_floor_q;
  assign out_o.car_dir     = out_dir_q;
  assign out_o.door_opened = out_opened_q;
  assign out_o.dwell_left  = out_dwell_q;
  assign out_o.status      = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The memory sweep runs once after reset and never again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("memory clear restarted");

  // The car never leaves the building.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(car_level_q) < FLOORS)
    else $error("car level out of range");

  // A tick with the door open only counts the dwell down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.func && (dwell_q != 4'd0)) |=>
      ((dwell_q == $past(dwell_q) - 4'd1) && $stable(car_level_q)))
    else $error("dwell countdown broken");

  // A direction decision moves the car by at most one floor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |=>
      ((car_level_q == $past(car_level_q)) ||
       (car_level_q == $past(car_level_q) + 1'b1) ||
       (car_level_q == $past(car_level_q) - 1'b1)))
    else $error("car jumped floors");

  // An idle decision leaves the car where it is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DECIDE) && (dir_nx == DIR_IDLE)) |=> $stable(car_level_q))
    else $error("idle car moved");

endmodule
